/* hdl/tdt_pkg.sv */
// Shared types, constants and tables of the terrain downward transmittance unit.
`default_nettype none

package tdt_pkg;

   // Stage counts
   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_LEN      = 24;
   localparam int CORDIC_N      = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN :
                                  ((CORDIC_STAGES < 0) ? 0 : CORDIC_STAGES);
   localparam int NUM_W         = 34;   // direct-term numerator width, one divider cell per bit
   localparam int DEN_W         = 17;   // divisor is twice the zenith cosine
   localparam int PIPE_DEPTH    = CORDIC_N + NUM_W + 7;

   // Datapath widths
   localparam int XY_W = 33;            // CORDIC x and y, signed Q2.30
   localparam int Z_W  = 27;            // CORDIC angle, 1/262144 degree

   localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic [19:0] OUT_MAX     = 20'hFFFFF;
   localparam logic [19:0] DIFFUSE_MAX = 20'd131072;

   // Configuration register indexes
   typedef enum logic [2:0] {
      REG_SUN_ZENITH        = 3'd0,
      REG_SUN_AZIMUTH       = 3'd1,
      REG_COS_SUN_ZENITH    = 3'd2,
      REG_TRANS_DOWN_TOTAL  = 3'd3,
      REG_TRANS_DOWN_DIRECT = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [12:0] slope;
      logic [14:0] aspect;
   } req_type;

   typedef struct packed {
      logic signed [15:0] incidence_cos;
      logic [15:0]        skyview;
      logic [19:0]        trans_effective;
      logic               in_shadow;
   } rsp_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   flip;
   } cordic_lane_type;

   // Lane 0: sun zenith, lane 1: slope, lane 2: azimuth difference
   typedef struct packed {
      logic                  valid;
      cordic_lane_type [2:0] lane;
   } cordic_bus_type;

   typedef struct packed {
      logic                  valid;
      logic [NUM_W-1:0]      num;
      logic [DEN_W-1:0]      rem;
      logic [NUM_W-1:0]      quo;
      logic signed [15:0]    inc;
      logic [15:0]           sky;
      logic [17:0]           diffuse;
      logic                  shadow;
   } div_bus_type;

   // Arctangent of 2^-i in 1/262144 degree
   function automatic logic signed [Z_W-1:0] cordic_atan(input logic [4:0] idx);
      logic signed [Z_W-1:0] val;
      unique case (idx)
         5'd0:    val = 27'sd11796480;
         5'd1:    val = 27'sd6963869;
         5'd2:    val = 27'sd3679517;
         5'd3:    val = 27'sd1867780;
         5'd4:    val = 27'sd937515;
         5'd5:    val = 27'sd469214;
         5'd6:    val = 27'sd234664;
         5'd7:    val = 27'sd117339;
         5'd8:    val = 27'sd58671;
         5'd9:    val = 27'sd29335;
         5'd10:   val = 27'sd14668;
         5'd11:   val = 27'sd7334;
         5'd12:   val = 27'sd3667;
         5'd13:   val = 27'sd1833;
         5'd14:   val = 27'sd917;
         5'd15:   val = 27'sd458;
         5'd16:   val = 27'sd229;
         5'd17:   val = 27'sd115;
         5'd18:   val = 27'sd57;
         5'd19:   val = 27'sd29;
         5'd20:   val = 27'sd14;
         5'd21:   val = 27'sd7;
         5'd22:   val = 27'sd4;
         5'd23:   val = 27'sd2;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

/* hdl/terrain_downward_transmittance_unit.sv */
// Top level: configuration registers, CORDIC cell row, incidence math and divider row.
`default_nettype none

// Takes one pixel request in every cycle (busy never rises) and returns one result per cycle,
// in request order, each marked by rsp_valid for a single cycle; the receiver must take it
// then. Each request passes the entry stage, the row of CORDIC cells (one per stage), stages
// A to D, stage E, the row of 34 restoring-division cells that form the direct term and the
// output stage. Write the csr_ registers only while no request is in flight.
module terrain_downward_transmittance_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire tdt_pkg::req_type req_data,
   output logic                  rsp_valid,
   output tdt_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic [2:0]       csr_index,
   input  wire logic [15:0]      csr_wdata
);

   localparam logic [15:0] FULL_TURN = 16'd23040;

   // Configuration registers
   logic [12:0] sun_zenith_ff;
   logic [14:0] sun_azimuth_ff;
   logic [15:0] cos_sun_zenith_ff, trans_total_ff, trans_direct_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sun_zenith_ff     <= '0;
         sun_azimuth_ff    <= '0;
         cos_sun_zenith_ff <= 16'd32768;
         trans_total_ff    <= 16'd32768;
         trans_direct_ff   <= 16'd32768;
      end else if (csr_we) begin
         unique case (csr_index)
            tdt_pkg::REG_SUN_ZENITH:        sun_zenith_ff     <= csr_wdata[12:0];
            tdt_pkg::REG_SUN_AZIMUTH:       sun_azimuth_ff    <= csr_wdata[14:0];
            tdt_pkg::REG_COS_SUN_ZENITH:    cos_sun_zenith_ff <= csr_wdata;
            tdt_pkg::REG_TRANS_DOWN_TOTAL:  trans_total_ff    <= csr_wdata;
            tdt_pkg::REG_TRANS_DOWN_DIRECT: trans_direct_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   logic [15:0] cdiv, tdif;
   assign cdiv = (cos_sun_zenith_ff == '0) ? 16'd1 : cos_sun_zenith_ff;
   assign tdif = (trans_total_ff > trans_direct_ff) ? trans_total_ff - trans_direct_ff : '0;

   function automatic logic [15:0] mod_turn(input logic [15:0] v);
      return (v >= FULL_TURN) ? v - FULL_TURN : v;
   endfunction

   // Fold an angle below a full turn into [-90, 90] degrees and seed a CORDIC lane
   function automatic tdt_pkg::cordic_lane_type seed_lane(input logic [15:0] a);
      tdt_pkg::cordic_lane_type ln;
      logic signed [15:0] theta;
      ln.flip = 1'b0;
      if (a <= 16'd5760) begin
         theta = $signed(a);
      end else if (a <= 16'd17280) begin
         theta = $signed(a) - 16'sd11520;
         ln.flip = 1'b1;
      end else begin
         theta = $signed(a) - 16'sd23040;
      end
      ln.x = tdt_pkg::CORDIC_GAIN;
      ln.y = '0;
      ln.z = tdt_pkg::Z_W'(theta) <<< 12;
      return ln;
   endfunction

   // Undo the fold and round half up to Q1.15, clamped to plus or minus one
   function automatic logic signed [16:0] to_q15(input logic signed [tdt_pkg::XY_W-1:0] v,
                                                 input logic flip);
      logic signed [tdt_pkg::XY_W:0] w;
      logic signed [tdt_pkg::XY_W:0] r;
      w = flip ? -(tdt_pkg::XY_W+1)'(v) : (tdt_pkg::XY_W+1)'(v);
      r = (w + 34'sd16384) >>> 15;
      if (r > 34'sd32768) begin
         r = 34'sd32768;
      end else if (r < -34'sd32768) begin
         r = -34'sd32768;
      end
      return r[16:0];
   endfunction

   // Entry stage: wrap angles, form azimuth difference, seed lanes
   tdt_pkg::cordic_bus_type cbus [tdt_pkg::CORDIC_N+1];
   tdt_pkg::cordic_bus_type entry_ff, entry_in;
   logic [15:0] saa, asp, diff;

   always_comb begin
      saa  = mod_turn({1'b0, sun_azimuth_ff});
      asp  = mod_turn({1'b0, req_data.aspect});
      diff = mod_turn(saa + FULL_TURN - asp);
      entry_in.valid   = start;
      entry_in.lane[0] = seed_lane({3'b0, sun_zenith_ff});
      entry_in.lane[1] = seed_lane({3'b0, req_data.slope});
      entry_in.lane[2] = seed_lane(diff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign cbus[0] = entry_ff;

   // Row of CORDIC cells
   for (genvar g = 0; g < tdt_pkg::CORDIC_N; g++) begin : g_cordic
      tdt_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (5'(g)),
         .bus_i     (cbus[g]),
         .bus_o     (cbus[g+1])
      );
   end

   // Stage A: sines and cosines in Q1.15
   logic a_valid_ff;
   logic signed [16:0] cz_ff, sz_ff, cp_ff, sp_ff, cd_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= cbus[tdt_pkg::CORDIC_N].valid;
      end
      cz_ff <= to_q15(cbus[tdt_pkg::CORDIC_N].lane[0].x, cbus[tdt_pkg::CORDIC_N].lane[0].flip);
      sz_ff <= to_q15(cbus[tdt_pkg::CORDIC_N].lane[0].y, cbus[tdt_pkg::CORDIC_N].lane[0].flip);
      cp_ff <= to_q15(cbus[tdt_pkg::CORDIC_N].lane[1].x, cbus[tdt_pkg::CORDIC_N].lane[1].flip);
      sp_ff <= to_q15(cbus[tdt_pkg::CORDIC_N].lane[1].y, cbus[tdt_pkg::CORDIC_N].lane[1].flip);
      cd_ff <= to_q15(cbus[tdt_pkg::CORDIC_N].lane[2].x, cbus[tdt_pkg::CORDIC_N].lane[2].flip);
   end

   // Stage B: first products and skyview
   logic b_valid_ff;
   logic signed [33:0] pcc_ff, pss_ff;
   logic signed [16:0] cdb_ff;
   logic [15:0] sky_b_ff;
   logic [17:0] sky_sum;
   assign sky_sum = 18'($signed(18'sd32769) + 18'(cp_ff));
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      pcc_ff   <= 34'(cz_ff) * 34'(cp_ff);
      pss_ff   <= 34'(sz_ff) * 34'(sp_ff);
      cdb_ff   <= cd_ff;
      sky_b_ff <= sky_sum[16:1];
   end

   // Stage C: incidence accumulator and diffuse product
   logic c_valid_ff;
   logic signed [47:0] acc_ff;
   logic [31:0] dprod_ff;
   logic [15:0] sky_c_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
      acc_ff   <= (48'(pcc_ff) <<< 15) + 48'(pss_ff) * 48'(cdb_ff);
      dprod_ff <= 32'(tdif) * 32'(sky_b_ff);
      sky_c_ff <= sky_b_ff;
   end

   // Stage D: round and saturate the incidence, scale the diffuse part
   logic d_valid_ff;
   logic signed [15:0] inc_d_ff;
   logic shadow_d_ff;
   logic [15:0] sky_d_ff;
   logic [17:0] diffuse_d_ff;
   logic signed [47:0] inc_wide;
   logic signed [15:0] inc_sat;
   logic [32:0] dround;
   always_comb begin
      inc_wide = (acc_ff + 48'sd536870912) >>> 30;
      if (inc_wide > 48'sd32767) begin
         inc_sat = 16'sd32767;
      end else if (inc_wide < -48'sd32768) begin
         inc_sat = -16'sd32768;
      end else begin
         inc_sat = inc_wide[15:0];
      end
      dround = 33'(dprod_ff) + 33'd8192;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= c_valid_ff;
      end
      inc_d_ff     <= inc_sat;
      shadow_d_ff  <= (inc_sat <= 16'sd0);
      sky_d_ff     <= sky_c_ff;
      diffuse_d_ff <= dround[31:14];
   end

   // Stage E: direct-term numerator, then the divider row
   tdt_pkg::div_bus_type dbus [tdt_pkg::NUM_W+1];
   tdt_pkg::div_bus_type div_ff, div_in;
   logic [tdt_pkg::DEN_W-1:0] divisor;
   assign divisor = {cdiv, 1'b0};
   always_comb begin
      div_in.valid   = d_valid_ff;
      div_in.rem     = '0;
      div_in.quo     = '0;
      div_in.inc     = inc_d_ff;
      div_in.sky     = sky_d_ff;
      div_in.diffuse = diffuse_d_ff;
      div_in.shadow  = shadow_d_ff;
      if (shadow_d_ff) begin
         div_in.num = '0;
      end else begin
         div_in.num = ((tdt_pkg::NUM_W'(trans_direct_ff) * tdt_pkg::NUM_W'(inc_d_ff[14:0])) << 2)
                      + tdt_pkg::NUM_W'(cdiv);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff.valid <= 1'b0;
      end else begin
         div_ff <= div_in;
      end
   end
   assign dbus[0] = div_ff;

   for (genvar g = 0; g < tdt_pkg::NUM_W; g++) begin : g_div
      tdt_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .divisor (divisor),
         .bus_i   (dbus[g]),
         .bus_o   (dbus[g+1])
      );
   end

   // Output stage: add and saturate, drive the result strobe
   tdt_pkg::div_bus_type fin;
   logic [tdt_pkg::NUM_W:0] total;
   assign fin   = dbus[tdt_pkg::NUM_W];
   assign total = (tdt_pkg::NUM_W+1)'(fin.diffuse) + (tdt_pkg::NUM_W+1)'(fin.quo);

   logic rsp_valid_ff;
   tdt_pkg::rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= fin.valid;
      end
      rsp_ff.incidence_cos   <= fin.inc;
      rsp_ff.skyview         <= fin.sky;
      rsp_ff.in_shadow       <= fin.shadow;
      rsp_ff.trans_effective <= (total > (tdt_pkg::NUM_W+1)'(tdt_pkg::OUT_MAX)) ?
                                tdt_pkg::OUT_MAX : total[19:0];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Every request yields a result on rsp_valid
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(tdt_pkg::PIPE_DEPTH) rsp_valid)
      else $error("result missing after request");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, tdt_pkg::PIPE_DEPTH))
      else $error("result without request");

   a_shadow_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.in_shadow == (rsp_data.incidence_cos <= 16'sd0)))
      else $error("shadow flag disagrees with incidence");

   a_shadow_diffuse: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.in_shadow) |-> (rsp_data.trans_effective <= tdt_pkg::DIFFUSE_MAX))
      else $error("shadowed pixel carries a direct term");

endmodule

`default_nettype wire

/* hdl/tdt_cordic_cell.sv */
// One CORDIC rotation cell, three angle lanes side by side.
`default_nettype none

module tdt_cordic_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [4:0]             stage_idx,
   input  wire tdt_pkg::cordic_bus_type bus_i,
   output tdt_pkg::cordic_bus_type     bus_o
);

   tdt_pkg::cordic_bus_type bus_ff, bus_in;
   logic signed [tdt_pkg::Z_W-1:0] atan_val;

   assign atan_val = tdt_pkg::cordic_atan(stage_idx);

   // Rotate each lane toward zero residual angle
   always_comb begin
      bus_in       = bus_i;
      for (int l = 0; l < 3; l++) begin
         if (bus_i.lane[l].z >= 0) begin
            bus_in.lane[l].x = bus_i.lane[l].x - (bus_i.lane[l].y >>> stage_idx);
            bus_in.lane[l].y = bus_i.lane[l].y + (bus_i.lane[l].x >>> stage_idx);
            bus_in.lane[l].z = bus_i.lane[l].z - atan_val;
         end else begin
            bus_in.lane[l].x = bus_i.lane[l].x + (bus_i.lane[l].y >>> stage_idx);
            bus_in.lane[l].y = bus_i.lane[l].y - (bus_i.lane[l].x >>> stage_idx);
            bus_in.lane[l].z = bus_i.lane[l].z + atan_val;
         end
      end
   end

   // Hand to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         bus_ff.valid <= 1'b0;
      end else begin
         bus_ff <= bus_in;
      end
   end

   assign bus_o = bus_ff;

endmodule

`default_nettype wire

/* hdl/tdt_div_cell.sv */
// One restoring-division cell: settles one quotient bit per stage.
`default_nettype none

module tdt_div_cell (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [tdt_pkg::DEN_W-1:0]  divisor,
   input  wire tdt_pkg::div_bus_type       bus_i,
   output tdt_pkg::div_bus_type            bus_o
);

   tdt_pkg::div_bus_type bus_ff, bus_in;
   logic [tdt_pkg::DEN_W:0] trial;
   logic                    fits;

   // Bring down the next numerator bit and try the subtract
   always_comb begin
      trial  = {bus_i.rem, bus_i.num[tdt_pkg::NUM_W-1]};
      fits   = (trial >= {1'b0, divisor});
      bus_in = bus_i;
      bus_in.num = {bus_i.num[tdt_pkg::NUM_W-2:0], 1'b0};
      bus_in.quo = {bus_i.quo[tdt_pkg::NUM_W-2:0], fits};
      if (fits) begin
         bus_in.rem = tdt_pkg::DEN_W'(trial - {1'b0, divisor});
      end else begin
         bus_in.rem = trial[tdt_pkg::DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_ff.valid <= 1'b0;
      end else begin
         bus_ff <= bus_in;
      end
   end

   assign bus_o = bus_ff;

endmodule

`default_nettype wire
